@@ src/sdq_pkg.sv @@
package sdq_pkg;

   // default configuration of the queue
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_SPACE_DEF    = 256;
   localparam int TIME_WIDTH_DEF  = 64;

   // fixed port widths
   localparam int OP_W        = 2;
   localparam int ID_W        = 8;
   localparam int TIME_PORT_W = 64;
   localparam int COUNT_W     = 5;
   localparam int KIND_W      = 2;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_EXPIRE = 2'd2
   } op_type;

   // response kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_DONE    = 2'd0,
      KIND_EXPIRED = 2'd1,
      KIND_NONE    = 2'd2,
      KIND_FULL    = 2'd3
   } kind_type;

   // response record handed from the sequencer to the output register
   typedef struct packed {
      kind_type             kind;
      logic [ID_W-1:0]      expired_id;
      logic [COUNT_W-1:0]   count;
      logic                 last;
   } rsp_info_type;

endpackage

@@ src/sorted_deadline_queue.sv @@
// Sorted deadline queue: keeps up to QUEUE_DEPTH entry ids ordered by wake
// time, earliest first, equal times in arrival order.
// Request channel (req_valid / req_stall): operation insert, remove or
// expire, with entry_id, wake_time (insert) and now_time (expire). Insert
// re-links an id that is already queued; a zero wake time is ignored.
// Response channel (rsp_valid / rsp_stall): one response per insert, remove
// or unknown operation; expire gives one response per popped id with last
// on the final one, or a single "nothing due" response.
// Timing: one request at a time. Insert and remove walk the slot memory one
// slot per cycle through a single compare unit. Expire pops one id per cycle
// while the response channel is not stalled, and then compacts the rest;
// with nothing due it stops at the head.
// The slot memory port (one read, one write per cycle) sets this pace.
// Reset empties the queue and clears all queued marks at once; no sweep.
// A stalled response holds in the output register; the sequencer waits on
// it, and requests are taken again once the current one has fully answered.
module sorted_deadline_queue #(
   parameter int QUEUE_DEPTH = sdq_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_SPACE    = sdq_pkg::ID_SPACE_DEF,
   parameter int TIME_WIDTH  = sdq_pkg::TIME_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sdq_pkg::OP_W-1:0]         req_operation,
   input  logic [sdq_pkg::ID_W-1:0]         req_entry_id,
   input  logic [sdq_pkg::TIME_PORT_W-1:0]  req_wake_time,
   input  logic [sdq_pkg::TIME_PORT_W-1:0]  req_now_time,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sdq_pkg::KIND_W-1:0]       rsp_kind,
   output logic [sdq_pkg::ID_W-1:0]         rsp_expired_id,
   output logic [sdq_pkg::TIME_PORT_W-1:0]  rsp_earliest_time,
   output logic [sdq_pkg::COUNT_W-1:0]      rsp_queue_count,
   output logic                             rsp_last
);

   localparam int ADDR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int TPORT_W = sdq_pkg::TIME_PORT_W;

   logic                          emit_valid;
   logic                          emit_ready;
   sdq_pkg::rsp_info_type         emit_info;
   logic [TIME_WIDTH-1:0]         emit_time;
   logic                          mem_wr_en;
   logic [ADDR_W-1:0]             mem_wr_addr;
   logic [TIME_WIDTH-1:0]         mem_wr_time;
   logic [sdq_pkg::ID_W-1:0]      mem_wr_id;
   logic                          mem_rd_en;
   logic [ADDR_W-1:0]             mem_rd_addr;
   logic [TIME_WIDTH-1:0]         mem_rd_time;
   logic [sdq_pkg::ID_W-1:0]      mem_rd_id;

   logic                          rsp_valid_ff, rsp_valid_in;
   sdq_pkg::rsp_info_type         rsp_info_ff;
   logic [TPORT_W-1:0]            rsp_time_ff;
   logic                          load;

   sdq_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_SPACE    (ID_SPACE),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_entry_id  (req_entry_id),
      .req_wake_time (req_wake_time),
      .req_now_time  (req_now_time),
      .emit_valid    (emit_valid),
      .emit_ready    (emit_ready),
      .emit_info     (emit_info),
      .emit_time     (emit_time),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_time   (mem_wr_time),
      .mem_wr_id     (mem_wr_id),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_time   (mem_rd_time),
      .mem_rd_id     (mem_rd_id)
   );

   sdq_slot_mem #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_time (mem_wr_time),
      .wr_id   (mem_wr_id),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_time (mem_rd_time),
      .rd_id   (mem_rd_id)
   );

   // output register
   assign emit_ready   = !rsp_valid_ff || !rsp_stall;
   assign load         = emit_valid && emit_ready;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_info_ff <= emit_info;
         rsp_time_ff <= TPORT_W'(emit_time);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_info_ff.kind;
   assign rsp_expired_id    = rsp_info_ff.expired_id;
   assign rsp_earliest_time = rsp_time_ff;
   assign rsp_queue_count   = rsp_info_ff.count;
   assign rsp_last          = rsp_info_ff.last;

`ifndef SYNTH
   // single responses always close their request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_info_ff.kind != sdq_pkg::KIND_EXPIRED)) |-> rsp_info_ff.last)
      else $error("non-expire response without last");

   // reported count never exceeds the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (int'(rsp_info_ff.count) <= QUEUE_DEPTH))
      else $error("queue count above depth");

   // an accepted request always occupies the sequencer in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken without going busy");
`endif

endmodule

@@ src/sdq_slot_mem.sv @@
module sdq_slot_mem #(
   parameter int QUEUE_DEPTH  = sdq_pkg::QUEUE_DEPTH_DEF,
   parameter int TIME_WIDTH   = sdq_pkg::TIME_WIDTH_DEF,
   localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [TIME_WIDTH-1:0]         wr_time,
   input  logic [sdq_pkg::ID_W-1:0]      wr_id,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [TIME_WIDTH-1:0]         rd_time,
   output logic [sdq_pkg::ID_W-1:0]      rd_id
);

   logic [TIME_WIDTH-1:0]     time_mem [QUEUE_DEPTH];
   logic [sdq_pkg::ID_W-1:0]  id_mem [QUEUE_DEPTH];
   logic [TIME_WIDTH-1:0]     rd_time_ff;
   logic [sdq_pkg::ID_W-1:0]  rd_id_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_time;
         id_mem[wr_addr]   <= wr_id;
      end
   end

   // registered read port, holds its data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_time_ff <= time_mem[rd_addr];
         rd_id_ff   <= id_mem[rd_addr];
      end
   end

   assign rd_time = rd_time_ff;
   assign rd_id   = rd_id_ff;

endmodule

@@ src/sdq_seq.sv @@
module sdq_seq #(
   parameter int QUEUE_DEPTH  = sdq_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_SPACE     = sdq_pkg::ID_SPACE_DEF,
   parameter int TIME_WIDTH   = sdq_pkg::TIME_WIDTH_DEF,
   localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   // request side
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sdq_pkg::OP_W-1:0]         req_operation,
   input  logic [sdq_pkg::ID_W-1:0]         req_entry_id,
   input  logic [sdq_pkg::TIME_PORT_W-1:0]  req_wake_time,
   input  logic [sdq_pkg::TIME_PORT_W-1:0]  req_now_time,
   // response hand-off
   output logic                             emit_valid,
   input  logic                             emit_ready,
   output sdq_pkg::rsp_info_type            emit_info,
   output logic [TIME_WIDTH-1:0]            emit_time,
   // slot memory
   output logic                             mem_wr_en,
   output logic [ADDR_W-1:0]                mem_wr_addr,
   output logic [TIME_WIDTH-1:0]            mem_wr_time,
   output logic [sdq_pkg::ID_W-1:0]         mem_wr_id,
   output logic                             mem_rd_en,
   output logic [ADDR_W-1:0]                mem_rd_addr,
   input  logic [TIME_WIDTH-1:0]            mem_rd_time,
   input  logic [sdq_pkg::ID_W-1:0]         mem_rd_id
);

   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_SLOTS = (ID_SPACE < 256) ? ID_SPACE : 256;
   localparam int QID_W    = $clog2(ID_SLOTS);
   localparam int COUNT_W  = sdq_pkg::COUNT_W;
   localparam int ID_W     = sdq_pkg::ID_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic                     ins_ff, ins_in;
   logic                     rem_ff, rem_in;
   logic                     exp_ff, exp_in;
   logic [ID_W-1:0]          key_id_ff, key_id_in;
   logic [TIME_WIDTH-1:0]    key_time_ff, key_time_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic                     dvalid_ff, dvalid_in;
   logic [CNT_W-1:0]         w_ff, w_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [TIME_WIDTH-1:0]    head_ff, head_in;
   logic                     carry_valid_ff, carry_valid_in;
   logic [TIME_WIDTH-1:0]    carry_time_ff, carry_time_in;
   logic [ID_W-1:0]          carry_id_ff, carry_id_in;
   logic                     inserted_ff, inserted_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]          pend_id_ff, pend_id_in;
   logic                     popped_ff, popped_in;
   sdq_pkg::kind_type        kind_ff, kind_in;
   logic [ID_SLOTS-1:0]      queued_ff, queued_in;

   logic                     gt;
   logic                     drop;
   logic                     need_emit;
   logic                     abort;
   logic                     id_ok;
   logic [QID_W-1:0]         req_qidx;
   logic [TIME_WIDTH-1:0]    wake_tw;
   logic [CNT_W-1:0]         next_cnt;
   logic [CNT_W-1:0]         left_cnt;

   // shared compare unit: stored time against the request key
   assign gt        = mem_rd_time > key_time_ff;
   assign drop      = (rem_ff && (mem_rd_id == key_id_ff)) || (exp_ff && !gt);
   assign need_emit = exp_ff && pend_valid_ff;
   assign abort     = exp_ff && !drop && !pend_valid_ff && !popped_ff;

   assign id_ok     = int'(req_entry_id) < ID_SPACE;
   assign req_qidx  = req_entry_id[QID_W-1:0];
   assign wake_tw   = req_wake_time[TIME_WIDTH-1:0];
   assign next_cnt  = CNT_W'(idx_ff) + CNT_W'(1);
   assign left_cnt  = fill_ff - CNT_W'(idx_ff);

   assign req_stall = (state_ff != S_IDLE);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      ins_in         = ins_ff;
      rem_in         = rem_ff;
      exp_in         = exp_ff;
      key_id_in      = key_id_ff;
      key_time_in    = key_time_ff;
      idx_in         = idx_ff;
      dvalid_in      = dvalid_ff;
      w_in           = w_ff;
      fill_in        = fill_ff;
      carry_valid_in = carry_valid_ff;
      carry_time_in  = carry_time_ff;
      carry_id_in    = carry_id_ff;
      inserted_in    = inserted_ff;
      pend_valid_in  = pend_valid_ff;
      pend_id_in     = pend_id_ff;
      popped_in      = popped_ff;
      kind_in        = kind_ff;
      queued_in      = queued_ff;

      emit_valid           = 1'b0;
      emit_info.kind       = sdq_pkg::KIND_DONE;
      emit_info.expired_id = '0;
      emit_info.count      = '0;
      emit_info.last       = 1'b1;
      emit_time            = '0;

      mem_wr_en   = 1'b0;
      mem_wr_addr = w_ff[ADDR_W-1:0];
      mem_wr_time = mem_rd_time;
      mem_wr_id   = mem_rd_id;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_id_in      = req_entry_id;
               key_time_in    = wake_tw;
               ins_in         = 1'b0;
               rem_in         = 1'b0;
               exp_in         = 1'b0;
               idx_in         = '0;
               dvalid_in      = 1'b0;
               w_in           = '0;
               carry_valid_in = 1'b0;
               inserted_in    = 1'b0;
               pend_valid_in  = 1'b0;
               popped_in      = 1'b0;
               kind_in        = sdq_pkg::KIND_DONE;
               state_in       = S_RESP;
               // decode the request
               unique case (req_operation)
                  sdq_pkg::OP_INSERT: begin
                     if (id_ok && (wake_tw != '0)) begin
                        if ((fill_ff == CNT_W'(QUEUE_DEPTH)) && !queued_ff[req_qidx]) begin
                           kind_in = sdq_pkg::KIND_FULL;
                        end else begin
                           ins_in              = 1'b1;
                           rem_in              = queued_ff[req_qidx];
                           queued_in[req_qidx] = 1'b1;
                           state_in            = S_SCAN;
                        end
                     end
                  end
                  sdq_pkg::OP_REMOVE: begin
                     if (id_ok && queued_ff[req_qidx]) begin
                        rem_in              = 1'b1;
                        queued_in[req_qidx] = 1'b0;
                        state_in            = S_SCAN;
                     end
                  end
                  sdq_pkg::OP_EXPIRE: begin
                     exp_in      = 1'b1;
                     key_time_in = req_now_time[TIME_WIDTH-1:0];
                     state_in    = S_SCAN;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
               // first slot read when a pass starts
               if ((state_in == S_SCAN) && (fill_ff != '0)) begin
                  mem_rd_en = 1'b1;
                  dvalid_in = 1'b1;
               end
            end
         end

         S_SCAN: begin
            if (dvalid_ff) begin
               if (!need_emit || emit_ready) begin
                  if (abort) begin
                     // nothing due at the head
                     dvalid_in = 1'b0;
                     kind_in   = sdq_pkg::KIND_NONE;
                     state_in  = S_RESP;
                  end else begin
                     // fetch the following slot
                     if (next_cnt < fill_ff) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = next_cnt[ADDR_W-1:0];
                        idx_in      = next_cnt[ADDR_W-1:0];
                     end else begin
                        dvalid_in = 1'b0;
                     end
                     // pending pop goes out with the new head
                     if (need_emit) begin
                        emit_valid           = 1'b1;
                        emit_info.kind       = sdq_pkg::KIND_EXPIRED;
                        emit_info.expired_id = pend_id_ff;
                        emit_info.count      = COUNT_W'(left_cnt);
                        emit_info.last       = !drop;
                        emit_time            = mem_rd_time;
                        pend_valid_in        = 1'b0;
                     end
                     if (drop) begin
                        if (exp_ff) begin
                           pend_valid_in = 1'b1;
                           pend_id_in    = mem_rd_id;
                           popped_in     = 1'b1;
                           if (int'(mem_rd_id) < ID_SLOTS) begin
                              queued_in[mem_rd_id[QID_W-1:0]] = 1'b0;
                           end
                        end
                     end else begin
                        // kept slot is written back compacted
                        mem_wr_en = 1'b1;
                        w_in      = w_ff + CNT_W'(1);
                        priority if (ins_ff && !inserted_ff && gt) begin
                           mem_wr_time    = key_time_ff;
                           mem_wr_id      = key_id_ff;
                           inserted_in    = 1'b1;
                           carry_valid_in = 1'b1;
                           carry_time_in  = mem_rd_time;
                           carry_id_in    = mem_rd_id;
                        end else if (carry_valid_ff) begin
                           mem_wr_time   = carry_time_ff;
                           mem_wr_id     = carry_id_ff;
                           carry_time_in = mem_rd_time;
                           carry_id_in   = mem_rd_id;
                        end else begin
                           mem_wr_time = mem_rd_time;
                           mem_wr_id   = mem_rd_id;
                        end
                     end
                  end
               end
            end else if (exp_ff) begin
               // end of an expire pass
               if (!pend_valid_ff || emit_ready) begin
                  if (pend_valid_ff) begin
                     emit_valid           = 1'b1;
                     emit_info.kind       = sdq_pkg::KIND_EXPIRED;
                     emit_info.expired_id = pend_id_ff;
                     emit_info.count      = '0;
                     emit_info.last       = 1'b1;
                     emit_time            = '0;
                     pend_valid_in        = 1'b0;
                  end
                  fill_in = w_ff;
                  if (popped_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     kind_in  = sdq_pkg::KIND_NONE;
                     state_in = S_RESP;
                  end
               end
            end else begin
               // end of an insert or remove pass
               fill_in  = w_ff;
               kind_in  = sdq_pkg::KIND_DONE;
               state_in = S_RESP;
               if (ins_ff && !inserted_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_time = key_time_ff;
                  mem_wr_id   = key_id_ff;
                  fill_in     = w_ff + CNT_W'(1);
               end else if (carry_valid_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_time = carry_time_ff;
                  mem_wr_id   = carry_id_ff;
                  fill_in     = w_ff + CNT_W'(1);
               end
            end
         end

         S_RESP: begin
            emit_valid           = 1'b1;
            emit_info.kind       = kind_ff;
            emit_info.expired_id = '0;
            emit_info.count      = COUNT_W'(fill_ff);
            emit_info.last       = 1'b1;
            emit_time            = (fill_ff != '0) ? head_ff : '0;
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // head time follows every write to the first slot
   assign head_in = (mem_wr_en && (mem_wr_addr == '0)) ? mem_wr_time : head_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         dvalid_ff     <= 1'b0;
         fill_ff       <= '0;
         queued_ff     <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dvalid_ff     <= dvalid_in;
         fill_ff       <= fill_in;
         queued_ff     <= queued_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // working registers of a pass
   always_ff @(posedge clock) begin
      ins_ff         <= ins_in;
      rem_ff         <= rem_in;
      exp_ff         <= exp_in;
      key_id_ff      <= key_id_in;
      key_time_ff    <= key_time_in;
      idx_ff         <= idx_in;
      w_ff           <= w_in;
      head_ff        <= head_in;
      carry_valid_ff <= carry_valid_in;
      carry_time_ff  <= carry_time_in;
      carry_id_ff    <= carry_id_in;
      inserted_ff    <= inserted_in;
      pend_id_ff     <= pend_id_in;
      popped_ff      <= popped_in;
      kind_ff        <= kind_in;
   end

endmodule
